[hdl/lbd_pkg.sv]
// ----------------------------------------------------------------------------
// lbd_pkg
// Shared constants, register indexes and controller/datapath signal groups
// for the lzss block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lbd_pkg;

  // history window
  localparam int WIN_DEPTH = 4096;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int CNT_W     = WIN_AW + 1;

  // default width of the size counter and config data
  localparam int SIZE_BITS_DEF = 24;

  // token fields
  localparam int LEN_W     = 5;
  localparam int MODE_W    = 3;
  localparam int FAULT_W   = 2;
  localparam int FLAG_IW   = 3;
  localparam logic [3:0]         LEN_MASK  = 4'hF;
  localparam logic [MODE_W-1:0]  MODE_MIN  = 3'd1;
  localparam logic [MODE_W-1:0]  MODE_MAX  = 3'd5;
  localparam logic [FLAG_IW-1:0] FLAG_LAST = 3'd7;

  // fault codes
  localparam logic [FAULT_W-1:0] FAULT_OK    = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_EARLY = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_TRUNC = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_COPY_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SIZE = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic take;       // input item accepted
    logic load_flag;  // capture flag byte
    logic load_lit;   // capture literal byte
    logic load_low;   // capture low byte of a reference
    logic load_ref;   // decode reference word into length, source, fault
    logic rd;         // read window at source address
    logic emit;       // push one byte to output and window
    logic emit_copy;  // emitted byte comes from the window read
    logic adv_flag;   // step to the next flag bit
  } lbd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic start;      // current input item opens a block
    logic active;     // bytes still owed for the block
    logic flag_bit;   // flag bit of the current token
    logic flag_last;  // current token is the eighth of its group
    logic copy_last;  // one byte left in the current copy
    logic out_free;   // output register can take a byte
  } lbd_sts_t;

endpackage

`default_nettype wire

[hdl/lbd_if.sv]
// ----------------------------------------------------------------------------
// lbd_if
// Valid/ready channel interfaces for compressed input and decoded output.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       block_start;

  modport source (output valid, output in_byte, output block_start, input ready);
  modport sink   (input valid, input in_byte, input block_start, output ready);
endinterface

interface lbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  logic [1:0] fault;

  modport source (output valid, output out_byte, output last_byte, output fault,
                  input ready);
  modport sink   (input valid, input out_byte, input last_byte, input fault,
                  output ready);
endinterface

`default_nettype wire

[hdl/lzss_block_decoder.sv]
// ----------------------------------------------------------------------------
// lzss_block_decoder
// LZSS block decoder with a 4096-byte history window: flag bytes, literals
// and 12-bit distance / 4-bit length references, bounded by an output size.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  in_ch    | in  | valid / ready      | in_byte[7:0], block_start
//  out_ch   | out | valid / ready      | out_byte[7:0], last_byte, fault[1:0]
//  cfg_*    | in  | cfg_we             | cfg_index (0 copy_mode, 1 output_size),
//           |     |                    | cfg_wdata[SIZE_BITS-1:0]
//
//  A flag byte or a reference low byte is only taken; a literal is taken, then
//  pushed; a reference high byte is taken, then each copied byte takes a
//  window read and then a push, for a reference of up to 21 bytes, the push
//  waiting on the registered window read ahead of it. Output stalls hold the
//  push step; an input item is taken while the last byte still sits in the
//  output register. A fill mark makes never-written window entries read as
//  zero, so no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_block_decoder #(
  parameter int SIZE_BITS = lbd_pkg::SIZE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  lbd_in_if.sink                             in_ch,
  lbd_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [lbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_BITS-1:0]          cfg_wdata
);
  import lbd_pkg::*;

  lbd_cmd_t cmd;
  lbd_sts_t sts;
  logic     in_ready;

  // parser and sequencer
  lbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // registers, window and output stage
  lbd_datapath #(
    .SIZE_BITS (SIZE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_byte     (in_ch.in_byte),
    .block_start (in_ch.block_start),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .last_byte   (out_ch.last_byte),
    .fault       (out_ch.fault),
    .cmd         (cmd),
    .sts         (sts)
  );

  assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

[hdl/lbd_ctrl.sv]
// ----------------------------------------------------------------------------
// lbd_ctrl
// Token parser and copy sequencer: tracks the parse phase and drives the
// datapath one step at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module lbd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lbd_pkg::lbd_sts_t sts,
  output lbd_pkg::lbd_cmd_t     cmd
);
  import lbd_pkg::*;

  typedef enum logic [2:0] {
    S_FLAG,   // waiting for a flag byte
    S_TOKEN,  // waiting for a literal or reference low byte
    S_HIGH,   // waiting for a reference high byte
    S_LIT,    // pushing a literal
    S_RD,     // reading one window byte
    S_WR      // pushing one copied byte
  } state_t;

  state_t state_r, state_nxt, phase;
  logic   accept;

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_FLAG) || (state_r == S_TOKEN) || (state_r == S_HIGH);
    accept    = in_valid && in_ready;
    phase     = sts.start ? S_FLAG : state_r;
    cmd.take  = accept;
    unique case (state_r)
      S_FLAG, S_TOKEN, S_HIGH: begin
        if (accept) begin
          state_nxt = phase;
          if (sts.active) begin
            unique case (phase)
              S_FLAG: begin
                cmd.load_flag = 1'b1;
                state_nxt     = S_TOKEN;
              end
              S_TOKEN: begin
                if (sts.flag_bit) begin
                  cmd.load_lit = 1'b1;
                  state_nxt    = S_LIT;
                end else begin
                  cmd.load_low = 1'b1;
                  state_nxt    = S_HIGH;
                end
              end
              S_HIGH: begin
                cmd.load_ref = 1'b1;
                state_nxt    = S_RD;
              end
              default: state_nxt = S_FLAG;
            endcase
          end
        end
      end
      S_LIT: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.adv_flag = 1'b1;
          state_nxt    = sts.flag_last ? S_FLAG : S_TOKEN;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_copy = 1'b1;
          if (sts.copy_last) begin
            cmd.adv_flag = 1'b1;
            state_nxt    = sts.flag_last ? S_FLAG : S_TOKEN;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_FLAG;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FLAG;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/lbd_datapath.sv]
// ----------------------------------------------------------------------------
// lbd_datapath
// Config registers, parse registers, byte counters, history window and the
// output register of the lzss block decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module lbd_datapath #(
  parameter int SIZE_BITS = lbd_pkg::SIZE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [lbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SIZE_BITS-1:0]          cfg_wdata,
  // input payload
  input  wire logic [7:0]                    in_byte,
  input  wire logic                          block_start,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_byte,
  output logic                               last_byte,
  output logic [lbd_pkg::FAULT_W-1:0]        fault,
  // control
  input  wire lbd_pkg::lbd_cmd_t             cmd,
  output lbd_pkg::lbd_sts_t                  sts
);
  import lbd_pkg::*;

  // config registers
  logic [MODE_W-1:0]    copy_mode_r;
  logic [SIZE_BITS-1:0] output_size_r;

  // parse and counting registers
  logic [7:0]           flag_bits_r;
  logic [FLAG_IW-1:0]   flag_index_r;
  logic [7:0]           low_r;
  logic [7:0]           lit_r;
  logic [WIN_AW-1:0]    wp_r;
  logic [CNT_W-1:0]     produced_r;
  logic [CNT_W-1:0]     fill_r;
  logic [SIZE_BITS-1:0] remaining_r;
  logic [WIN_AW-1:0]    src_r;
  logic [LEN_W-1:0]     len_r;
  logic [FAULT_W-1:0]   fault_r;

  // window memory and its read register
  logic [7:0]           mem [WIN_DEPTH];
  logic [7:0]           rd_data_r;
  logic                 rd_zero_r;

  // output register
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 last_byte_r;
  logic [FAULT_W-1:0]   fault_out_r;

  // reference decode
  logic [15:0]          word;
  logic [MODE_W-1:0]    mode;
  logic [LEN_W-1:0]     ref_len;
  logic [CNT_W-1:0]     ref_dist;
  logic [WIN_AW-1:0]    ref_src;
  logic                 ref_trunc;
  logic                 ref_early;
  logic [FAULT_W-1:0]   ref_fault;
  logic [7:0]           emit_byte;
  logic [FAULT_W-1:0]   emit_fault;

  always_comb begin
    word      = {in_byte, low_r};
    mode      = ((copy_mode_r >= MODE_MIN) && (copy_mode_r <= MODE_MAX)) ?
                copy_mode_r : MODE_MIN;
    ref_len   = LEN_W'(word[3:0] & LEN_MASK) + LEN_W'(mode) + LEN_W'(1);
    ref_dist  = CNT_W'(word[15:4]) + CNT_W'(1);
    ref_src   = wp_r - word[15:4] - WIN_AW'(1);
    ref_trunc = SIZE_BITS'(ref_len) > remaining_r;
    ref_early = ref_dist > produced_r;
    if (ref_early) begin
      ref_fault = FAULT_EARLY;
    end else if (ref_trunc) begin
      ref_fault = FAULT_TRUNC;
    end else begin
      ref_fault = FAULT_OK;
    end
    emit_byte  = cmd.emit_copy ? (rd_zero_r ? 8'h00 : rd_data_r) : lit_r;
    emit_fault = cmd.emit_copy ? fault_r : FAULT_OK;
  end

  // status to controller
  always_comb begin
    sts.start     = block_start;
    sts.active    = block_start ? (output_size_r != '0) : (remaining_r != '0);
    sts.flag_bit  = flag_bits_r[flag_index_r];
    sts.flag_last = (flag_index_r == FLAG_LAST);
    sts.copy_last = (len_r == LEN_W'(1));
    sts.out_free  = !out_valid_r || out_ready;
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      copy_mode_r   <= MODE_MIN;
      output_size_r <= SIZE_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COPY_MODE:   copy_mode_r   <= cfg_wdata[MODE_W-1:0];
        REG_OUTPUT_SIZE: output_size_r <= cfg_wdata;
        default:         copy_mode_r   <= copy_mode_r;
      endcase
    end
  end

  // parse state and byte counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_bits_r  <= '0;
      flag_index_r <= '0;
      low_r        <= '0;
      wp_r         <= '0;
      produced_r   <= '0;
      fill_r       <= '0;
      remaining_r  <= '0;
      len_r        <= '0;
    end else begin
      if (cmd.take && block_start) begin
        low_r        <= '0;
        wp_r         <= '0;
        produced_r   <= '0;
        remaining_r  <= output_size_r;
      end
      // flag group: new flag byte, cleared by a block start, or next token
      if (cmd.load_flag) begin
        flag_bits_r  <= in_byte;
        flag_index_r <= '0;
      end else if (cmd.take && block_start) begin
        flag_bits_r  <= '0;
        flag_index_r <= '0;
      end else if (cmd.adv_flag) begin
        flag_index_r <= flag_index_r + FLAG_IW'(1);
      end
      if (cmd.load_low) begin
        low_r <= in_byte;
      end
      if (cmd.load_ref) begin
        len_r <= ref_trunc ? LEN_W'(remaining_r) : ref_len;
      end
      if (cmd.emit) begin
        wp_r        <= wp_r + WIN_AW'(1);
        remaining_r <= remaining_r - SIZE_BITS'(1);
        if (produced_r != CNT_W'(WIN_DEPTH)) begin
          produced_r <= produced_r + CNT_W'(1);
        end
        // writes start at zero each block, so written entries form a prefix
        if ({1'b0, wp_r} == fill_r) begin
          fill_r <= fill_r + CNT_W'(1);
        end
        if (cmd.emit_copy) begin
          len_r <= len_r - LEN_W'(1);
        end
      end
    end
  end

  // copy source, literal and fault holding registers
  always_ff @(posedge clk) begin
    if (cmd.load_lit) begin
      lit_r <= in_byte;
    end
    if (cmd.load_ref) begin
      src_r   <= ref_src;
      fault_r <= ref_fault;
    end else if (cmd.rd) begin
      src_r <= src_r + WIN_AW'(1);
    end
  end

  // history window: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      mem[wp_r] <= emit_byte;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[src_r];
    end
  end

  // entries beyond the fill mark have never been written and read as zero
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_zero_r <= ({1'b0, src_r} >= fill_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r  <= emit_byte;
      last_byte_r <= (remaining_r == SIZE_BITS'(1));
      fault_out_r <= emit_fault;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign last_byte = last_byte_r;
  assign fault     = fault_out_r;

  // checks
  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("byte pushed onto an occupied output register");

  a_emit_owed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (remaining_r != '0))
    else $error("byte pushed with nothing owed for the block");

  a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd || cmd.emit_copy) |-> (len_r != '0))
    else $error("copy step with zero length left");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= CNT_W'(WIN_DEPTH)) && (produced_r <= CNT_W'(WIN_DEPTH)))
    else $error("window count beyond window depth");

  a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> !cmd.rd)
    else $error("window read issued twice without a push");

endmodule

`default_nettype wire

[verif/lzss_block_decoder_test.sv]
// ----------------------------------------------------------------------------
// lzss_block_decoder_test
// Self-checking bench for the lzss block decoder. A directed table covers
// idle input, size limits, early and truncated references, invalid modes,
// split references and zero-size blocks. Randomised blocks with random
// settings follow. Every decoded item is compared with a bit-level
// predictor or a table entry, under random stalls on both channels.
// ----------------------------------------------------------------------------
module lzss_block_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lbd_pkg::*;

  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int ITEM_TARGET   = 430;
  localparam int MAX_SHOWN     = 10;

  typedef struct packed {
    logic [7:0]         data;
    logic               last;
    logic [FAULT_W-1:0] fault;
  } dec_byte_t;

  typedef enum logic [1:0] {SEEK_FLAG, SEEK_TOKEN, SEEK_HIGH} seek_t;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [23:0]          val;
    logic                 start;
    logic                 typed;
    int                   cnt;
    dec_byte_t            res;
  } plan_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [SIZE_BITS_DEF-1:0] cfg_wdata;

  lbd_in_if  in_ch ();
  lbd_out_if out_ch ();

  lzss_block_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state and settings
  logic [7:0]  window_copy [WIN_DEPTH];
  logic [11:0] wr_ptr;
  logic [7:0]  flags;
  logic [2:0]  flag_pos;
  seek_t       seek;
  logic [7:0]  low_byte;
  logic [23:0] remaining;
  int          produced;
  logic [2:0]  mode_reg;
  logic [23:0] size_reg;
  logic        item_taken;

  dec_byte_t   fresh_bytes [$];
  dec_byte_t   expected_bytes [$];
  plan_row_t   plan [$];
  int          decoded_items;
  int          fails;
  int          cycle_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // append one decoded byte to the window and the fresh list
  function automatic void put_byte(logic [7:0] v, logic [FAULT_W-1:0] f);
    dec_byte_t b;
    window_copy[wr_ptr] = v;
    wr_ptr = wr_ptr + 12'd1;
    if (produced < WIN_DEPTH) produced++;
    remaining = remaining - 24'd1;
    b.data  = v;
    b.last  = (remaining == 24'd0);
    b.fault = f;
    fresh_bytes.push_back(b);
  endfunction

  // step to the next token of the flag group
  function automatic void next_token();
    if (flag_pos == FLAG_LAST) begin
      flag_pos = 3'd0;
      seek     = SEEK_FLAG;
    end else begin
      flag_pos = flag_pos + 3'd1;
      seek     = SEEK_TOKEN;
    end
  endfunction

  // predictor: decode one input item into fresh_bytes
  task automatic decode_item(input logic [7:0] b, input logic s);
    logic [15:0]        word;
    logic [11:0]        src;
    logic [FAULT_W-1:0] flt;
    int                 eff_mode;
    int                 len;
    int                 back;
    int                 i;
    fresh_bytes.delete();
    item_taken = 1'b0;
    if (s) begin
      seek      = SEEK_FLAG;
      flag_pos  = 3'd0;
      flags     = 8'd0;
      low_byte  = 8'd0;
      wr_ptr    = 12'd0;
      produced  = 0;
      remaining = size_reg;
    end
    if (remaining == 24'd0) return;
    item_taken = 1'b1;
    case (seek)
      SEEK_FLAG: begin
        flags    = b;
        flag_pos = 3'd0;
        seek     = SEEK_TOKEN;
      end
      SEEK_TOKEN: begin
        if (flags[flag_pos]) begin
          put_byte(b, FAULT_OK);
          next_token();
        end else begin
          low_byte = b;
          seek     = SEEK_HIGH;
        end
      end
      default: begin
        word     = {b, low_byte};
        eff_mode = (mode_reg >= MODE_MIN && mode_reg <= MODE_MAX) ?
                   int'(mode_reg) : int'(MODE_MIN);
        len      = int'(word[3:0] & LEN_MASK) + eff_mode + 1;
        back     = int'(word[15:4]) + 1;
        src      = wr_ptr - 12'(back);
        flt      = FAULT_OK;
        if (len > int'(remaining)) begin
          len = int'(remaining);
          flt = FAULT_TRUNC;
        end
        // early reference outranks truncation
        if (back > produced) flt = FAULT_EARLY;
        for (i = 0; i < len; i++) begin
          put_byte(window_copy[src], flt);
          src = src + 12'd1;
        end
        next_token();
      end
    endcase
  endtask

  // offer one item, wait for the handshake, then predict
  task automatic send_item(input logic [7:0] b, input logic s, input logic typed = 1'b0,
                           input int cnt = 0, input dec_byte_t res = '0);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.in_byte     <= b;
    in_ch.block_start <= s;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    decode_item(b, s);
    if (item_taken) decoded_items++;
    if (typed) begin
      if (cnt > 0) expected_bytes.push_back(res);
    end else begin
      foreach (fresh_bytes[k]) expected_bytes.push_back(fresh_bytes[k]);
    end
  endtask

  // stop sending, wait for all results, then let the block go quiet
  task automatic settle();
    @(negedge clk) in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, block idle
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk) cfg_we <= 1'b0;
    if (idx == REG_COPY_MODE) mode_reg = val[2:0];
    else size_reg = val;
  endtask

  // table rows
  function automatic plan_row_t item_row(logic [7:0] b, logic s);
    plan_row_t r;
    r.kind  = ROW_ITEM;
    r.idx   = REG_COPY_MODE;
    r.val   = {16'd0, b};
    r.start = s;
    r.typed = 1'b0;
    r.cnt   = 0;
    r.res   = '0;
    return r;
  endfunction

  function automatic plan_row_t item_known(logic [7:0] b, logic s, int cnt, logic [7:0] d,
                                           logic l, logic [FAULT_W-1:0] f);
    plan_row_t r;
    r           = item_row(b, s);
    r.typed     = 1'b1;
    r.cnt       = cnt;
    r.res.data  = d;
    r.res.last  = l;
    r.res.fault = f;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    plan_row_t r;
    r      = item_row(8'd0, 1'b0);
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  // one randomised block, mostly well formed
  task automatic random_block();
    int          budget;
    int          r;
    int          lim;
    int          back;
    logic [11:0] field;
    logic [3:0]  nib;
    logic [7:0]  hi;
    if ($urandom_range(0, 9) < 7) begin
      settle();
      set_register(REG_COPY_MODE, ($urandom_range(0, 9) < 8) ?
                   24'($urandom_range(1, 5)) : 24'($urandom_range(0, 7)));
      r = $urandom_range(0, 99);
      if (r < 8)       set_register(REG_OUTPUT_SIZE, 24'd0);
      else if (r < 14) set_register(REG_OUTPUT_SIZE, 24'hFFFFFF);
      else if (r < 20) set_register(REG_OUTPUT_SIZE, 24'($urandom_range(4096, 24'hFFFFFE)));
      else if (r < 30) set_register(REG_OUTPUT_SIZE, 24'd1);
      else             set_register(REG_OUTPUT_SIZE, 24'($urandom_range(2, 150)));
    end
    send_item(8'($urandom()), 1'b1);
    budget = $urandom_range(4, 60);
    while (remaining != 24'd0 && budget > 0 && decoded_items < ITEM_TARGET) begin
      budget--;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        // block restarted mid-stream
        send_item(8'($urandom()), 1'b1);
      end else if (r < 7) begin
        send_item(8'($urandom()), 1'b0);
      end else if (seek == SEEK_TOKEN && !flags[flag_pos]) begin
        // reference mostly into bytes already produced
        if (produced == 0 || $urandom_range(0, 99) < 8) begin
          field = 12'($urandom());
        end else begin
          lim   = (produced < 16 || $urandom_range(0, 99) < 40) ?
                  ((produced < 16) ? produced : 16) : produced;
          back  = $urandom_range(1, lim);
          field = 12'(back - 1);
        end
        nib = 4'($urandom());
        hi  = field[11:4];
        send_item({field[3:0], nib}, 1'b0);
        // occasionally a new block cuts the reference in two
        send_item(hi, ($urandom_range(0, 99) < 4));
      end else begin
        // flag byte, literal, or stray high byte after noise
        send_item(8'($urandom()), 1'b0);
      end
    end
    // trailing input the block should ignore
    if (remaining == 24'd0 && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_item(8'($urandom()), 1'b0);
  endtask

  // output sink: random stalls, long open stretches now and then
  initial begin
    int stall;
    int run;
    wait (rst_n === 1'b1);
    forever begin
      stall = pick_gap();
      run   = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      if (stall > 0) begin
        @(negedge clk) out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_ch.ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    dec_byte_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_bytes.size() == 0) begin
        fails++;
        if (fails <= MAX_SHOWN)
          $display("unexpected item: byte %02h last %0b fault %0d",
                   out_ch.out_byte, out_ch.last_byte, out_ch.fault);
      end else begin
        want = expected_bytes.pop_front();
        if (out_ch.out_byte !== want.data || out_ch.last_byte !== want.last ||
            out_ch.fault !== want.fault) begin
          fails++;
          if (fails <= MAX_SHOWN)
            $display("mismatch: expected byte %02h last %0b fault %0d, got %02h %0b %0d",
                     want.data, want.last, want.fault,
                     out_ch.out_byte, out_ch.last_byte, out_ch.fault);
        end
      end
    end
  end

  // main sequence
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_COPY_MODE;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.in_byte     = 8'd0;
    in_ch.block_start = 1'b0;
    out_ch.ready      = 1'b0;
    fails             = 0;
    cycle_count       = 0;
    decoded_items     = 0;

    // predictor after reset
    foreach (window_copy[k]) window_copy[k] = 8'd0;
    wr_ptr    = 12'd0;
    flags     = 8'd0;
    flag_pos  = 3'd0;
    seek      = SEEK_FLAG;
    low_byte  = 8'd0;
    remaining = 24'd0;
    produced  = 0;
    mode_reg  = 3'd1;
    size_reg  = 24'd1;

    // idle after reset, then a one-byte block on the reset settings
    plan.push_back(item_known(8'h41, 1'b0, 0, 8'h00, 1'b0, FAULT_OK));
    plan.push_back(item_known(8'hFF, 1'b1, 0, 8'h00, 1'b0, FAULT_OK));
    plan.push_back(item_known(8'hAB, 1'b0, 1, 8'hAB, 1'b1, FAULT_OK));
    plan.push_back(item_known(8'h12, 1'b0, 0, 8'h00, 1'b0, FAULT_OK));
    // longest copy, early reference, short copy, truncated copy, then idle
    plan.push_back(cfg_row(REG_COPY_MODE, 24'd5));
    plan.push_back(cfg_row(REG_OUTPUT_SIZE, 24'd40));
    plan.push_back(item_known(8'h01, 1'b1, 0, 8'h00, 1'b0, FAULT_OK));
    plan.push_back(item_known(8'hA5, 1'b0, 1, 8'hA5, 1'b0, FAULT_OK));
    plan.push_back(item_row(8'h0F, 1'b0));
    plan.push_back(item_row(8'h00, 1'b0));
    plan.push_back(item_row(8'h00, 1'b0));
    plan.push_back(item_row(8'hFF, 1'b0));
    plan.push_back(item_row(8'h10, 1'b0));
    plan.push_back(item_row(8'h00, 1'b0));
    plan.push_back(item_row(8'h0F, 1'b0));
    plan.push_back(item_row(8'h00, 1'b0));
    plan.push_back(item_known(8'h77, 1'b0, 0, 8'h00, 1'b0, FAULT_OK));
    // invalid mode acts as mode one, largest size, reference cut by a new block
    plan.push_back(cfg_row(REG_COPY_MODE, 24'd7));
    plan.push_back(cfg_row(REG_OUTPUT_SIZE, 24'hFFFFFF));
    plan.push_back(item_known(8'hF9, 1'b1, 0, 8'h00, 1'b0, FAULT_OK));
    plan.push_back(item_known(8'h11, 1'b0, 1, 8'h11, 1'b0, FAULT_OK));
    plan.push_back(item_row(8'h00, 1'b0));
    plan.push_back(item_row(8'h00, 1'b0));
    plan.push_back(item_known(8'h3F, 1'b0, 0, 8'h00, 1'b0, FAULT_OK));
    plan.push_back(item_known(8'hFF, 1'b1, 0, 8'h00, 1'b0, FAULT_OK));
    plan.push_back(item_known(8'hFF, 1'b0, 1, 8'hFF, 1'b0, FAULT_OK));
    plan.push_back(item_known(8'h80, 1'b0, 1, 8'h80, 1'b0, FAULT_OK));
    // zero size leaves the block idle
    plan.push_back(cfg_row(REG_OUTPUT_SIZE, 24'd0));
    plan.push_back(item_known(8'h00, 1'b1, 0, 8'h00, 1'b0, FAULT_OK));
    plan.push_back(item_known(8'h55, 1'b0, 0, 8'h00, 1'b0, FAULT_OK));

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (i == 0 || plan[i-1].kind != ROW_CFG) settle();
        set_register(plan[i].idx, plan[i].val);
      end else begin
        send_item(plan[i].val[7:0], plan[i].start, plan[i].typed, plan[i].cnt, plan[i].res);
      end
    end

    // random blocks
    decoded_items = 0;
    while (decoded_items < ITEM_TARGET) random_block();

    settle();
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/lbd_pkg.sv
hdl/lbd_if.sv
hdl/lbd_ctrl.sv
hdl/lbd_datapath.sv
hdl/lzss_block_decoder.sv
verif/lzss_block_decoder_test.sv
